// ===== hw/rtl/hsl2rgb_pkg.sv =====
// Shared constants for the HSL to RGB color converter.
package hsl2rgb_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HX6_W  = 11;

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam logic [9:0]        CHROMA_TOP = 10'd512;
  localparam logic [8:0]        FRAC_TOP   = 9'd256;

  // Sextant codes: which sixth of the color circle the hue lies in.
  localparam logic [2:0] SEXT_RED_YEL  = 3'd0;
  localparam logic [2:0] SEXT_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEXT_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEXT_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEXT_BLU_MAG  = 3'd4;

endpackage

// ===== hw/rtl/hsl_to_rgb_converter.sv =====
// Top level of the pipelined 8-bit HSL to RGB color converter.
//
// The converter takes one 8-bit hue, saturation and lightness request and
// returns 8-bit red, green and blue. A request is taken at every rising clock
// edge where start is high; busy is always low, so one pixel enters per clock
// and one pixel leaves per clock. The pipeline has four register stages: a
// result appears on the out_ ports once its request has passed all four,
// flagged by out_valid for exactly one cycle. The receiver cannot stall, and
// none is needed: the pipeline never backs up. The stages follow the two
// chained 9-by-8-bit multiplies (chroma, then the secondary component), each
// with its own stage, framed by one stage for the chroma factor and one for
// the channel sums.
module hsl_to_rgb_converter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_hue,
  input  logic [7:0] in_saturation,
  input  logic [7:0] in_lightness,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  import hsl2rgb_pkg::*;

  // Stage 1: chroma scale factor and hue times six.
  logic              s1_valid_r;
  logic [8:0]        s1_factor_r;
  logic [7:0]        s1_sat_r;
  logic [7:0]        s1_light_r;
  logic [HX6_W-1:0]  s1_hx6_r;

  // Stage 2: chroma.
  logic              s2_valid_r;
  logic [7:0]        s2_chroma_r;
  logic [7:0]        s2_light_r;
  logic [HX6_W-1:0]  s2_hx6_r;

  // Stage 3: secondary component and offset.
  logic              s3_valid_r;
  logic [7:0]        s3_chroma_r;
  logic [7:0]        s3_sec_r;
  logic [7:0]        s3_offs_r;
  logic [2:0]        s3_sext_r;
  logic              s3_black_r;

  // Stage 4: output registers.
  logic              out_valid_r;
  logic [7:0]        red_r;
  logic [7:0]        green_r;
  logic [7:0]        blue_r;

  logic [8:0]        lp1;
  logic [9:0]        lp1_x2;
  logic [9:0]        factor_wide;
  logic [8:0]        factor_nxt;
  logic [HX6_W-1:0]  hx6_nxt;
  logic [16:0]       chroma_prod;
  logic [8:0]        frac;
  logic [8:0]        ramp;
  logic [16:0]       sec_prod;
  logic [7:0]        offs_nxt;
  logic [7:0]        rc;
  logic [7:0]        gc;
  logic [7:0]        bc;
  logic [8:0]        red_sum;
  logic [8:0]        green_sum;
  logic [8:0]        blue_sum;
  logic [7:0]        red_nxt;
  logic [7:0]        green_nxt;
  logic [7:0]        blue_nxt;

  // The pipeline never stalls, so a request is always welcome.
  assign busy = 1'b0;

  // Chroma factor: 2*(L+1) in the dark half, 512 - 2*(L+1) in the light half.
  // Both stay within nine bits for every 8-bit lightness.
  assign lp1         = {1'b0, in_lightness} + 9'd1;
  assign lp1_x2      = {lp1, 1'b0};
  assign factor_wide = in_lightness[7] ? (CHROMA_TOP - lp1_x2) : lp1_x2;
  assign factor_nxt  = factor_wide[8:0];
  assign hx6_nxt     = {1'b0, in_hue, 2'b00} + {2'b00, in_hue, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start;
    end
    s1_factor_r <= factor_nxt;
    s1_sat_r    <= in_saturation;
    s1_light_r  <= in_lightness;
    s1_hx6_r    <= hx6_nxt;
  end

  // Chroma is the high byte of factor times saturation.
  assign chroma_prod = s1_factor_r * s1_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_chroma_r <= chroma_prod[15:8];
    s2_light_r  <= s1_light_r;
    s2_hx6_r    <= s1_hx6_r;
  end

  // The secondary component ramps up on even sextants and down on odd ones.
  assign frac     = {1'b0, s2_hx6_r[7:0]} + 9'd1;
  assign ramp     = s2_hx6_r[8] ? (FRAC_TOP - frac) : frac;
  assign sec_prod = ramp * s2_chroma_r;
  assign offs_nxt = s2_light_r - {1'b0, s2_chroma_r[7:1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_chroma_r <= s2_chroma_r;
    s3_sec_r    <= sec_prod[15:8];
    s3_offs_r   <= offs_nxt;
    s3_sext_r   <= s2_hx6_r[10:8];
    s3_black_r  <= (s2_light_r == 8'd0);
  end

  // Place chroma, secondary and zero on the channels by sextant. The last
  // sextant, and any code beyond it, uses the magenta-to-red placement.
  always_comb begin
    unique case (s3_sext_r)
      SEXT_RED_YEL: begin
        rc = s3_chroma_r; gc = s3_sec_r;    bc = 8'd0;
      end
      SEXT_YEL_GRN: begin
        rc = s3_sec_r;    gc = s3_chroma_r; bc = 8'd0;
      end
      SEXT_GRN_CYN: begin
        rc = 8'd0;        gc = s3_chroma_r; bc = s3_sec_r;
      end
      SEXT_CYN_BLU: begin
        rc = 8'd0;        gc = s3_sec_r;    bc = s3_chroma_r;
      end
      SEXT_BLU_MAG: begin
        rc = s3_sec_r;    gc = 8'd0;        bc = s3_chroma_r;
      end
      default: begin
        rc = s3_chroma_r; gc = 8'd0;        bc = s3_sec_r;
      end
    endcase
  end

  // Add the offset and clamp at full scale. Zero lightness forces black.
  assign red_sum   = {1'b0, rc} + {1'b0, s3_offs_r};
  assign green_sum = {1'b0, gc} + {1'b0, s3_offs_r};
  assign blue_sum  = {1'b0, bc} + {1'b0, s3_offs_r};

  assign red_nxt   = s3_black_r ? 8'd0 : (red_sum[8]   ? CHAN_MAX : red_sum[7:0]);
  assign green_nxt = s3_black_r ? 8'd0 : (green_sum[8] ? CHAN_MAX : green_sum[7:0]);
  assign blue_nxt  = s3_black_r ? 8'd0 : (blue_sum[8]  ? CHAN_MAX : blue_sum[7:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_valid_r;
    end
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;

endmodule
